// File: sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define CHK_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`endif

// File: sv/iplpr_pkg.sv
// types and constants of the ipv4 longest-prefix route table
// no dependencies
package iplpr_pkg;

    localparam int unsigned ROUTE_ENTRIES_DEF = 16;
    localparam logic [5:0] MAX_PREFIX = 6'd32;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_REMOVE_IF = 3'd2,
        ACT_FIND = 3'd3,
        ACT_GET_GW = 3'd4,
        ACT_EXISTS = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_ARG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] gateway;
        logic [5:0] prefix;
        logic [7:0] flags;
        logic [3:0] iface;
    } route_t;

    function automatic logic [31:0] mask_of(input logic [5:0] plen);
        logic [31:0] m;
        m = '0;
        if (plen >= MAX_PREFIX) begin
            m = ALL_ONES;
        end else if (plen != 6'd0) begin
            m = ~(ALL_ONES >> plen[4:0]);
        end
        return m;
    endfunction

endpackage

// File: sv/ipv4_longest_prefix_route_table_unit.sv
// Route table of ROUTE_ENTRIES ipv4 routes kept sorted by prefix length, longest first.
// One compare unit scans the stored routes one entry per cycle, and an insert or delete
// then moves entries one per cycle. A word with a bad argument goes straight to the result;
// remove by interface scans on after each deleted route. A result waits while
// m_axis_tready is low. s_axis_tready is high only when idle.
// Depends on iplpr_pkg.
module ipv4_longest_prefix_route_table_unit #(
    parameter int unsigned ROUTE_ENTRIES = iplpr_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[2:0], dest_addr[34:3], prefix_length[40:35], gateway_addr[72:41],
    // iface_id[76:73], flag_bits[84:77], zero fill to 88
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], hit[2], hit_iface[6:3], hit_gateway[38:7], hit_dest[70:39],
    // hit_prefix[76:71], hit_flags[84:77], zero fill to 88
    output logic [87:0]  m_axis_tdata
);
    localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ROUTE_ENTRIES);

    iplpr_pkg::route_t table_mem [ROUTE_ENTRIES];

    iplpr_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [2:0]  act_reg;
    logic [31:0] dest_reg, gw_reg;
    logic [5:0]  plen_reg;
    logic [3:0]  if_reg;
    logic [7:0]  fl_reg;
    logic [1:0]  status_reg, status_next;
    logic        hit_reg, hit_next;
    iplpr_pkg::route_t hit_route_reg, hit_route_next;
    logic        found_reg, found_next;

    // one compare unit on the entry under the scan index
    iplpr_pkg::route_t cur;
    logic [31:0] cur_mask, in_mask;
    logic in_range, exact_m, route_m, flag_m;
    logic [IW-1:0] idx_a;

    assign idx_a = idx_reg[IW-1:0];
    assign in_range = idx_reg < count_reg;
    assign cur = table_mem[idx_a];
    assign cur_mask = iplpr_pkg::mask_of(cur.prefix);
    assign in_mask = iplpr_pkg::mask_of(plen_reg);
    assign exact_m = (cur.prefix == plen_reg) && ((cur.dest & in_mask) == (dest_reg & in_mask))
        && ((if_reg == 4'd0) || (cur.iface == if_reg));
    assign route_m = (dest_reg & cur_mask) == (cur.dest & cur_mask);
    assign flag_m = (cur.flags & fl_reg) == fl_reg;

    logic [2:0] in_act;
    logic [5:0] in_plen;
    logic [3:0] in_if;
    logic       in_bad;
    assign in_act = s_axis_tdata[2:0];
    assign in_plen = s_axis_tdata[40:35];
    assign in_if = s_axis_tdata[76:73];
    always_comb begin
        case (in_act)
            iplpr_pkg::ACT_ADD: in_bad = (in_if == 4'd0) || (in_plen > iplpr_pkg::MAX_PREFIX);
            iplpr_pkg::ACT_REMOVE: in_bad = in_plen > iplpr_pkg::MAX_PREFIX;
            iplpr_pkg::ACT_REMOVE_IF, iplpr_pkg::ACT_FIND: in_bad = 1'b0;
            iplpr_pkg::ACT_GET_GW, iplpr_pkg::ACT_EXISTS: in_bad = in_if == 4'd0;
            default: in_bad = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iplpr_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = in_bad ? iplpr_pkg::S_OUT : iplpr_pkg::S_SCAN;
                end
            end
            iplpr_pkg::S_SCAN: begin
                if (!in_range) begin
                    if (act_reg == iplpr_pkg::ACT_ADD && count_reg != FULL_CNT) begin
                        state_next = iplpr_pkg::S_SHIFT_UP;
                    end else begin
                        state_next = iplpr_pkg::S_OUT;
                    end
                end else begin
                    case (act_reg)
                        iplpr_pkg::ACT_ADD: if (exact_m) state_next = iplpr_pkg::S_OUT;
                        iplpr_pkg::ACT_REMOVE: if (exact_m) state_next = iplpr_pkg::S_SHIFT_DOWN;
                        iplpr_pkg::ACT_REMOVE_IF:
                            if (cur.iface == if_reg && flag_m) state_next = iplpr_pkg::S_SHIFT_DOWN;
                        iplpr_pkg::ACT_FIND:
                            if (cur.iface != 4'd0 && route_m) state_next = iplpr_pkg::S_OUT;
                        iplpr_pkg::ACT_GET_GW:
                            if (cur.iface == if_reg && route_m) state_next = iplpr_pkg::S_OUT;
                        iplpr_pkg::ACT_EXISTS:
                            if (cur.iface == if_reg && flag_m) state_next = iplpr_pkg::S_OUT;
                        default: state_next = iplpr_pkg::S_OUT;
                    endcase
                end
            end
            iplpr_pkg::S_SHIFT_UP: begin
                if (idx_reg == pos_reg) state_next = iplpr_pkg::S_OUT;
            end
            iplpr_pkg::S_SHIFT_DOWN: begin
                if (idx_reg + CW'(1) >= count_reg) begin
                    state_next = (act_reg == iplpr_pkg::ACT_REMOVE_IF) ? iplpr_pkg::S_SCAN
                                                                      : iplpr_pkg::S_OUT;
                end
            end
            iplpr_pkg::S_OUT: begin
                if (m_axis_tready) state_next = iplpr_pkg::S_IDLE;
            end
            default: state_next = iplpr_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        idx_next = idx_reg;
        pos_next = pos_reg;
        count_next = count_reg;
        status_next = status_reg;
        hit_next = hit_reg;
        hit_route_next = hit_route_reg;
        found_next = found_reg;
        case (state_reg)
            iplpr_pkg::S_IDLE: begin
                idx_next = '0;
                found_next = 1'b0;
                hit_next = 1'b0;
                hit_route_next = '0;
                status_next = in_bad ? iplpr_pkg::ST_ARG : iplpr_pkg::ST_OK;
                pos_next = count_reg;
            end
            iplpr_pkg::S_SCAN: begin
                if (!in_range) begin
                    if (act_reg == iplpr_pkg::ACT_ADD) begin
                        if (count_reg == FULL_CNT) begin
                            status_next = iplpr_pkg::ST_FULL;
                        end else begin
                            idx_next = count_reg;
                        end
                    end
                end else begin
                    idx_next = idx_reg + CW'(1);
                    case (act_reg)
                        iplpr_pkg::ACT_ADD: begin
                            if (!found_reg && plen_reg > cur.prefix) begin
                                found_next = 1'b1;
                                pos_next = idx_reg;
                            end
                            if (exact_m) found_next = 1'b1;
                        end
                        iplpr_pkg::ACT_REMOVE, iplpr_pkg::ACT_REMOVE_IF: begin
                            if (state_next == iplpr_pkg::S_SHIFT_DOWN) idx_next = idx_reg;
                        end
                        default: begin
                            if (state_next == iplpr_pkg::S_OUT) begin
                                hit_next = 1'b1;
                                hit_route_next = cur;
                            end
                        end
                    endcase
                end
            end
            iplpr_pkg::S_SHIFT_UP: begin
                if (idx_reg == pos_reg) count_next = count_reg + CW'(1);
                else idx_next = idx_reg - CW'(1);
            end
            iplpr_pkg::S_SHIFT_DOWN: begin
                if (idx_reg + CW'(1) >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    idx_next = pos_reg;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default: ;
        endcase
        // deletion resumes the scan where it began
        if (state_reg == iplpr_pkg::S_SCAN && state_next == iplpr_pkg::S_SHIFT_DOWN) begin
            pos_next = idx_reg;
        end
        // the found flag records the first longer-prefix slot, exact match ends in S_OUT
        if (state_reg == iplpr_pkg::S_SCAN && in_range && act_reg == iplpr_pkg::ACT_ADD
            && found_reg && !exact_m) begin
            found_next = 1'b1;
        end
    end

    // table writes
    logic [IW-1:0] idx_m1, idx_p1;
    assign idx_m1 = idx_a - IW'(1);
    assign idx_p1 = idx_a + IW'(1);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ROUTE_ENTRIES; k++) table_mem[k] <= '0;
        end else begin
            case (state_reg)
                iplpr_pkg::S_SCAN: begin
                    if (in_range && act_reg == iplpr_pkg::ACT_ADD && exact_m) begin
                        table_mem[idx_a].gateway <= gw_reg;
                        table_mem[idx_a].flags <= fl_reg;
                    end
                end
                iplpr_pkg::S_SHIFT_UP: begin
                    if (idx_reg == pos_reg) begin
                        table_mem[idx_a] <= '{dest: dest_reg & in_mask, gateway: gw_reg,
                            prefix: plen_reg, flags: fl_reg, iface: if_reg};
                    end else begin
                        table_mem[idx_a] <= table_mem[idx_m1];
                    end
                end
                iplpr_pkg::S_SHIFT_DOWN: begin
                    if (idx_reg + CW'(1) >= count_reg) table_mem[idx_a] <= '0;
                    else table_mem[idx_a] <= table_mem[idx_p1];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iplpr_pkg::S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        hit_reg <= hit_next;
        hit_route_reg <= hit_route_next;
        if (state_reg == iplpr_pkg::S_IDLE && s_axis_tvalid) begin
            act_reg <= in_act;
            dest_reg <= s_axis_tdata[34:3];
            plen_reg <= in_plen;
            gw_reg <= s_axis_tdata[72:41];
            if_reg <= in_if;
            fl_reg <= s_axis_tdata[84:77];
        end
    end

    // outputs
    always_comb begin
        s_axis_tready = state_reg == iplpr_pkg::S_IDLE;
        m_axis_tvalid = state_reg == iplpr_pkg::S_OUT;
        m_axis_tdata = {3'b000, hit_route_reg.flags, hit_route_reg.prefix, hit_route_reg.dest,
            hit_route_reg.gateway, hit_route_reg.iface, hit_reg, status_reg};
    end

endmodule

// File: sv/iplpr_checker.sv
// port-level checks of the route table unit
// depends on assert_macros.svh and ipv4_longest_prefix_route_table_unit
`include "assert_macros.svh"
module iplpr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    `CHK_ALWAYS(a_one_side, aclk, aresetn, !(s_axis_tready && m_axis_tvalid), "busy both sides")
    `CHK_IMPL(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)), "result dropped")
    `CHK_IMPL(a_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, ##1 !s_axis_tready, "took two words")
    `CHK_IMPL(a_miss, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[84:3] == 82'd0, "miss fields set")
    `CHK_IMPL(a_status, aclk, aresetn, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad status")
endmodule

bind ipv4_longest_prefix_route_table_unit iplpr_checker u_iplpr_checker (.*);
